/* rtl/dpq_pkg.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// dpq_pkg: shared types and constants of the drop-oldest descriptor queue
// Operation codes, status codes, the descriptor layout and the request and
// result payloads used on the channels and between the queue modules.
// ---------------------------------------------------------------------------
package dpq_pkg;

  localparam int unsigned DepthDflt = 64;

  localparam int unsigned ModeW   = 3;
  localparam int unsigned StatusW = 2;
  localparam int unsigned LimitW  = 7;
  localparam int unsigned OccW    = 7;
  localparam int unsigned BytesW  = 38;
  localparam int unsigned SumW    = 39;
  localparam int unsigned TotalW  = 64;

  localparam logic [15:0] TypeLimit = 16'd10000;

  typedef enum logic [ModeW-1:0] {
    MODE_ENQ     = 3'd0,
    MODE_ENQ_CHK = 3'd1,
    MODE_DEQ     = 3'd2,
    MODE_STOP    = 3'd3,
    MODE_CLEAR   = 3'd4,
    MODE_QUERY   = 3'd5
  } mode_e;

  typedef enum logic [StatusW-1:0] {
    ST_OK      = 2'd0,
    ST_STOPPED = 2'd1,
    ST_EMPTY   = 2'd2,
    ST_BADTYPE = 2'd3
  } status_e;

  typedef struct packed {
    logic [15:0] packet_type;
    logic [31:0] client_ident;
    logic [31:0] payload_length;
    logic [31:0] payload_crc;
  } desc_t;

  typedef struct packed {
    logic [ModeW-1:0] mode;
    logic [15:0]      packet_type;
    logic [31:0]      client_ident;
    logic [31:0]      payload_length;
    logic [31:0]      payload_crc;
  } req_t;

  typedef struct packed {
    logic [StatusW-1:0] status;
    logic               dropped_now;
    logic [15:0]        out_type;
    logic [31:0]        out_client;
    logic [31:0]        out_length;
    logic [31:0]        out_crc;
    logic [OccW-1:0]    occupancy;
    logic [BytesW-1:0]  bytes_held;
    logic [TotalW-1:0]  enqueued_total;
    logic [TotalW-1:0]  dequeued_total;
    logic [TotalW-1:0]  dropped_total;
  } rsp_t;

  // Sequencing from the front end to the queue core.
  typedef struct packed {
    logic rd_en;   // read the oldest ring entry for the operation just taken
    logic commit;  // apply the held operation and publish its result
  } core_ctl_t;

endpackage

/* rtl/dpq_req_if.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// dpq_req_if: request channel of the descriptor queue
// Valid/ready channel that carries one operation with its descriptor.
// ---------------------------------------------------------------------------
interface dpq_req_if;
  logic          valid;
  logic          ready;
  dpq_pkg::req_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* rtl/dpq_rsp_if.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// dpq_rsp_if: result channel of the descriptor queue
// Valid/ready channel that carries one result with status and totals.
// ---------------------------------------------------------------------------
interface dpq_rsp_if;
  logic          valid;
  logic          ready;
  dpq_pkg::rsp_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* rtl/dpq_ram.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// dpq_ram: generic single-write, single-read synchronous RAM
// One write port, one read port with a registered read that holds its data.
// ---------------------------------------------------------------------------
module dpq_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/dpq_core.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// dpq_core: ring state and read-modify-write of the descriptor queue
// Holds head, count, byte sum, totals and the stop flag next to the ring
// RAM, and works out each operation's result from the oldest entry.
// ---------------------------------------------------------------------------
module dpq_core #(
  parameter int unsigned DEPTH = dpq_pkg::DepthDflt
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  dpq_pkg::core_ctl_t          ctl_i,
  input  dpq_pkg::req_t               op_i,
  input  logic [dpq_pkg::LimitW-1:0]  max_entries_i,
  output dpq_pkg::rsp_t               result_o
);
  import dpq_pkg::*;

  localparam int unsigned PtrW  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW  = $clog2(DEPTH + 1);
  localparam int unsigned PsumW = CntW + 1;
  localparam int unsigned LimW  = (CntW > LimitW) ? CntW : LimitW;

  logic [PtrW-1:0]   head_q, head_d;
  logic [CntW-1:0]   count_q, count_d;
  logic [SumW-1:0]   sum_q, sum_d;
  logic [TotalW-1:0] enq_q, enq_d, deq_q, deq_d, drp_q, drp_d;
  logic              stopped_q, stopped_d;

  desc_t           oldest;
  desc_t           wr_desc;
  logic [PsumW-1:0] tail_sum;
  logic [PtrW-1:0] tail_ptr;
  logic [PtrW-1:0] head_inc;
  logic [LimW-1:0] lim_in, lim;
  logic            is_enq, bad_type;
  logic            do_enq, do_deq, do_clr, do_stop, drop, pop, deq_empty;
  logic [SumW-1:0] sub_len, add_len;

  // Tail slot: head plus count, folded back into the ring.
  assign tail_sum = PsumW'(head_q) + PsumW'(count_q);
  assign tail_ptr = (tail_sum >= PsumW'(DEPTH)) ? PtrW'(tail_sum - PsumW'(DEPTH))
                                                : PtrW'(tail_sum);
  assign head_inc = (head_q == PtrW'(DEPTH - 1)) ? '0 : head_q + 1'b1;

  assign lim_in = LimW'(max_entries_i);
  assign lim    = (lim_in == '0 || lim_in > LimW'(DEPTH)) ? LimW'(DEPTH) : lim_in;

  assign wr_desc = '{packet_type:    op_i.packet_type,
                     client_ident:   op_i.client_ident,
                     payload_length: op_i.payload_length,
                     payload_crc:    op_i.payload_crc};

  dpq_ram #(
    .WIDTH ($bits(desc_t)),
    .DEPTH (DEPTH)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (ctl_i.commit && do_enq),
    .waddr_i (tail_ptr),
    .wdata_i (wr_desc),
    .re_i    (ctl_i.rd_en),
    .raddr_i (head_q),
    .rdata_o (oldest)
  );

  always_comb begin
    is_enq    = (op_i.mode == MODE_ENQ) || (op_i.mode == MODE_ENQ_CHK);
    bad_type  = (op_i.mode == MODE_ENQ_CHK) &&
                ((op_i.packet_type == '0) || (op_i.packet_type > TypeLimit));
    do_enq    = !stopped_q && is_enq && !bad_type;
    drop      = do_enq && (LimW'(count_q) >= lim) && (count_q != '0);
    deq_empty = !stopped_q && (op_i.mode == MODE_DEQ) && (count_q == '0);
    do_deq    = !stopped_q && (op_i.mode == MODE_DEQ) && (count_q != '0);
    do_clr    = !stopped_q && (op_i.mode == MODE_CLEAR);
    do_stop   = !stopped_q && (op_i.mode == MODE_STOP);
    pop       = drop || do_deq;

    head_d    = head_q;
    count_d   = count_q;
    enq_d     = enq_q;
    deq_d     = deq_q;
    drp_d     = drp_q;
    stopped_d = stopped_q || do_stop;

    sub_len = pop ? SumW'(oldest.payload_length) : '0;
    add_len = do_enq ? SumW'(op_i.payload_length) : '0;
    sum_d   = do_clr ? '0 : sum_q - sub_len + add_len;

    if (pop) begin
      head_d = head_inc;
    end else if (do_clr) begin
      head_d = tail_ptr;
    end

    if (do_enq && !drop) begin
      count_d = count_q + 1'b1;
    end else if (do_deq) begin
      count_d = count_q - 1'b1;
    end else if (do_clr) begin
      count_d = '0;
    end

    if (do_enq) enq_d = enq_q + 1'b1;
    if (drop)   drp_d = drp_q + 1'b1;
    if (do_deq) begin
      deq_d = deq_q + 1'b1;
    end else if (do_clr) begin
      deq_d = deq_q + TotalW'(count_q);
    end

    result_o.status = ST_OK;
    if (stopped_q) begin
      result_o.status = ST_STOPPED;
    end else if (is_enq && bad_type) begin
      result_o.status = ST_BADTYPE;
    end else if (deq_empty) begin
      result_o.status = ST_EMPTY;
    end
    result_o.dropped_now    = drop;
    result_o.out_type       = do_deq ? oldest.packet_type    : '0;
    result_o.out_client     = do_deq ? oldest.client_ident   : '0;
    result_o.out_length     = do_deq ? oldest.payload_length : '0;
    result_o.out_crc        = do_deq ? oldest.payload_crc    : '0;
    result_o.occupancy      = OccW'(count_d);
    result_o.bytes_held     = sum_d[BytesW-1:0];
    result_o.enqueued_total = enq_d;
    result_o.dequeued_total = deq_d;
    result_o.dropped_total  = drp_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q    <= '0;
      count_q   <= '0;
      sum_q     <= '0;
      enq_q     <= '0;
      deq_q     <= '0;
      drp_q     <= '0;
      stopped_q <= 1'b0;
    end else if (ctl_i.commit) begin
      head_q    <= head_d;
      count_q   <= count_d;
      sum_q     <= sum_d;
      enq_q     <= enq_d;
      deq_q     <= deq_d;
      drp_q     <= drp_d;
      stopped_q <= stopped_d;
    end
  end

endmodule

/* rtl/drop_oldest_packet_queue.sv */
`timescale 1ns / 1ps
// Sequence: a request transfer reads the oldest entry from the ring RAM; the held operation
//   is applied and its result loaded once the output register is free or drains. No new
//   request is taken meanwhile: the read must land before the read-modify-write.
// Reset: pointers, count, byte sum, totals, stop flag, limit and valid flags clear at once;
//   the ring RAM is not cleared, since only occupied entries' data is ever used.
// ---------------------------------------------------------------------------
// drop_oldest_packet_queue: bounded descriptor queue that drops the oldest
// Ring of packet descriptors with enqueue, checked enqueue, dequeue, stop,
// clear and query; full enqueues evict the oldest entry and count the drop.
// ---------------------------------------------------------------------------
module drop_oldest_packet_queue #(
  parameter int unsigned DEPTH = dpq_pkg::DepthDflt
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [dpq_pkg::LimitW-1:0] cfg_wdata_i,
  dpq_req_if.sink                    req_i,
  dpq_rsp_if.source                  rsp_o
);
  import dpq_pkg::*;

  // Two-step sequencer: take a request and read the oldest entry, then
  // apply it and load the result register.
  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } state_e;

  state_e     state_q, state_d;
  req_t       op_q;
  rsp_t       result;
  rsp_t       rsp_q;
  logic       rsp_valid_q, rsp_valid_d;
  logic [LimitW-1:0] max_entries_q;
  logic       accept;
  logic       commit;
  core_ctl_t  ctl;

  // Limit register: the user must write it only while the queue is idle; not enforced.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_entries_q <= '0;
    end else if (cfg_we_i) begin
      max_entries_q <= cfg_wdata_i;
    end
  end

  // Take a request only between operations. The result register is a
  // separate stage, so a pending result does not block the next transfer.
  assign req_i.ready = (state_q == S_IDLE);
  assign accept      = req_i.valid && req_i.ready;

  // Apply the held operation once the result register is free or drains now.
  assign commit = (state_q == S_EXEC) && (!rsp_valid_q || rsp_o.ready);

  assign ctl.rd_en  = accept;
  assign ctl.commit = commit;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) state_d = S_EXEC;
      end
      S_EXEC: begin
        if (commit) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Hold the operation for the execute state.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q <= req_i.data;
    end
  end

  dpq_core #(
    .DEPTH (DEPTH)
  ) u_core (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .ctl_i         (ctl),
    .op_i          (op_q),
    .max_entries_i (max_entries_q),
    .result_o      (result)
  );

  // Output register: load on commit, drop the valid flag after its transfer.
  always_comb begin
    rsp_valid_d = rsp_valid_q;
    if (commit) begin
      rsp_valid_d = 1'b1;
    end else if (rsp_o.ready) begin
      rsp_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_valid_q <= 1'b0;
    end else begin
      rsp_valid_q <= rsp_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (commit) begin
      rsp_q <= result;
    end
  end

  assign rsp_o.valid = rsp_valid_q;
  assign rsp_o.data  = rsp_q;

  // A taken request always moves the sequencer into execute.
  a_accept_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q == S_EXEC))
    else $error("request transfer did not start execution");

  // A committed operation always leaves a result behind.
  a_commit_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    commit |=> rsp_valid_q)
    else $error("committed operation left no result");

  // An empty dequeue reports no occupancy and no drop.
  a_empty_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_q && (rsp_q.status == ST_EMPTY)) |->
      ((rsp_q.occupancy == '0) && !rsp_q.dropped_now && (rsp_q.out_type == '0)))
    else $error("empty dequeue result is inconsistent");

  // A drop only happens on a successful enqueue.
  a_drop_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_q && rsp_q.dropped_now) |-> (rsp_q.status == ST_OK))
    else $error("drop reported with a failing status");

endmodule

/* sim/tb_drop_oldest_packet_queue.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_drop_oldest_packet_queue: self-checking bench for the descriptor queue
// Walks a short table of directed operations around random phases under
// several queue limits. A built-in copy of the queue state predicts every
// result, and each result is checked field by field, in order.
// ---------------------------------------------------------------------------
module tb_drop_oldest_packet_queue;
  import dpq_pkg::*;

  localparam int unsigned QDEPTH      = DepthDflt;
  localparam int          IDLE_PCT    = 8;
  localparam int          CYCLE_LIMIT = 400_000;
  localparam int          HOLD_CYCLES = 300;
  localparam int          NUM_PHASES  = 12;
  localparam int          PHASE_OPS   = 135;

  // Spare operation codes; the block treats both as a query.
  localparam logic [ModeW-1:0] MODE_SPARE6 = 3'd6;
  localparam logic [ModeW-1:0] MODE_SPARE7 = 3'd7;

  logic              clk_i;
  logic              rst_ni;
  logic              cfg_we_i;
  logic [LimitW-1:0] cfg_wdata_i;

  dpq_req_if req_if ();
  dpq_rsp_if rsp_if ();

  drop_oldest_packet_queue #(
    .DEPTH(QDEPTH)
  ) u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .req_i      (req_if),
    .rsp_o      (rsp_if)
  );

  // -------------------------------------------------------------------------
  // Clock and run control
  // -------------------------------------------------------------------------
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  int  cycle_count;
  int  mismatch_count;
  int  results_seen;
  int  limit_writes;
  int  op_count [8];
  bit  calm;            // suppress idling on both sides
  bit  stall_rsp_req;   // ask the result side for one long hold-off

  // -------------------------------------------------------------------------
  // Queue state as the bench predicts it
  // -------------------------------------------------------------------------
  desc_t             ring_copy [QDEPTH];
  int unsigned       q_head;
  int unsigned       q_count;
  logic [SumW-1:0]   q_bytes;
  logic [TotalW-1:0] q_enq;
  logic [TotalW-1:0] q_deq;
  logic [TotalW-1:0] q_drop;
  bit                q_stopped;
  logic [LimitW-1:0] q_limit;

  rsp_t queue_results_due [$];

  // Remove the oldest held descriptor; callers make sure one is held.
  function automatic desc_t take_oldest();
    desc_t s;
    s       = ring_copy[q_head];
    q_head  = (q_head + 1) % QDEPTH;
    q_count = q_count - 1;
    q_bytes = q_bytes - SumW'(s.payload_length);
    return s;
  endfunction

  // Apply one operation to the predicted state and return its result.
  function automatic rsp_t next_queue_result(input req_t op);
    rsp_t        o;
    desc_t       s;
    int unsigned lim_eff;
    o       = '0;
    lim_eff = (q_limit == 0 || q_limit > QDEPTH) ? QDEPTH : q_limit;
    if (q_stopped) begin
      // stop is sticky: nothing moves, not even a type check
      o.status = ST_STOPPED;
    end else begin
      case (op.mode)
        MODE_ENQ, MODE_ENQ_CHK: begin
          if (op.mode == MODE_ENQ_CHK &&
              (op.packet_type == 16'd0 || op.packet_type > TypeLimit)) begin
            o.status = ST_BADTYPE;
          end else begin
            // at the limit, evict exactly one; a lowered limit keeps occupancy
            if (q_count >= lim_eff && q_count > 0) begin
              s             = take_oldest();
              q_drop        = q_drop + 1;
              o.dropped_now = 1'b1;
            end
            ring_copy[(q_head + q_count) % QDEPTH] =
              {op.packet_type, op.client_ident, op.payload_length, op.payload_crc};
            q_count = q_count + 1;
            q_bytes = q_bytes + SumW'(op.payload_length);
            q_enq   = q_enq + 1;
          end
        end
        MODE_DEQ: begin
          if (q_count == 0) begin
            o.status = ST_EMPTY;
          end else begin
            s            = take_oldest();
            o.out_type   = s.packet_type;
            o.out_client = s.client_ident;
            o.out_length = s.payload_length;
            o.out_crc    = s.payload_crc;
            q_deq        = q_deq + 1;
          end
        end
        MODE_STOP: begin
          q_stopped = 1'b1;
        end
        MODE_CLEAR: begin
          // drained entries count as dequeued, never as dropped
          q_deq   = q_deq + q_count;
          q_head  = (q_head + q_count) % QDEPTH;
          q_count = 0;
          q_bytes = '0;
        end
        default: begin
        end
      endcase
    end
    o.occupancy      = q_count[OccW-1:0];
    o.bytes_held     = q_bytes[BytesW-1:0];
    o.enqueued_total = q_enq;
    o.dequeued_total = q_deq;
    o.dropped_total  = q_drop;
    return o;
  endfunction

  // -------------------------------------------------------------------------
  // Result checking
  // -------------------------------------------------------------------------
  task automatic report_mismatch(input string what);
    $display("MISMATCH at cycle %0d: %s", cycle_count, what);
    mismatch_count++;
  endtask

  task automatic check_field(input string name, input logic [63:0] seen,
                             input logic [63:0] due);
    if (seen !== due) begin
      report_mismatch($sformatf("result %0d %s: got 0x%0h, expected 0x%0h",
                                results_seen, name, seen, due));
    end
  endtask

  // Sample at the edge: a transfer happens where valid and ready were both high.
  always @(posedge clk_i) begin : rsp_check
    rsp_t seen;
    rsp_t due;
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      seen = rsp_if.data;
      if (queue_results_due.size() == 0) begin
        report_mismatch("result transfer with no result outstanding");
      end else begin
        due = queue_results_due.pop_front();
        check_field("status",         seen.status,         due.status);
        check_field("dropped_now",    seen.dropped_now,    due.dropped_now);
        check_field("out_type",       seen.out_type,       due.out_type);
        check_field("out_client",     seen.out_client,     due.out_client);
        check_field("out_length",     seen.out_length,     due.out_length);
        check_field("out_crc",        seen.out_crc,        due.out_crc);
        check_field("occupancy",      seen.occupancy,      due.occupancy);
        check_field("bytes_held",     seen.bytes_held,     due.bytes_held);
        check_field("enqueued_total", seen.enqueued_total, due.enqueued_total);
        check_field("dequeued_total", seen.dequeued_total, due.dequeued_total);
        check_field("dropped_total",  seen.dropped_total,  due.dropped_total);
      end
      results_seen++;
    end
  end

  // -------------------------------------------------------------------------
  // Result side: random stalls, calm stretches and one long hold-off
  // -------------------------------------------------------------------------
  initial begin : rsp_drain
    int hold_left;
    hold_left     = 0;
    rsp_if.ready  = 1'b0;
    forever begin
      @(posedge clk_i);
      if (stall_rsp_req) begin
        stall_rsp_req = 1'b0;
        hold_left     = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        // hold off so the output register fills and the request side backs up
        rsp_if.ready <= 1'b0;
        hold_left--;
      end else if (calm) begin
        rsp_if.ready <= 1'b1;
      end else begin
        rsp_if.ready <= ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  // -------------------------------------------------------------------------
  // Request side
  // -------------------------------------------------------------------------
  // Offer one operation, hold it until the transfer, then predict its result.
  // Where typed is set, status, dropped_now and (occ >= 0) occupancy come
  // from the directed table instead of the predictor.
  task automatic send_op(input req_t op, input bit typed, input status_e st,
                         input int occ, input logic drop);
    rsp_t due;
    if (!calm && $urandom_range(99) < IDLE_PCT) begin
      req_if.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    req_if.valid <= 1'b1;
    req_if.data  <= op;
    do @(posedge clk_i); while (!req_if.ready);
    due = next_queue_result(op);
    if (typed) begin
      due.status      = st;
      due.dropped_now = drop;
      if (occ >= 0) due.occupancy = occ[OccW-1:0];
    end
    queue_results_due.push_back(due);
    op_count[op.mode]++;
  endtask

  // Drop valid and wait until every outstanding result has come back.
  task automatic wait_drained();
    req_if.valid <= 1'b0;
    while (queue_results_due.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_limit(input logic [LimitW-1:0] value);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    q_limit      = value;
    limit_writes++;
  endtask

  // -------------------------------------------------------------------------
  // Directed table. Config rows change the limit while the queue is quiet.
  // Rows from TAIL_ROW on stop the queue and run at the very end of the test.
  // -------------------------------------------------------------------------
  typedef struct {
    bit                is_cfg;
    logic [LimitW-1:0] limit;
    logic [ModeW-1:0]  mode;
    logic [15:0]       ptype;
    logic [31:0]       client;
    logic [31:0]       len;
    logic [31:0]       crc;
    bit                typed;
    status_e           st;
    int                occ;
    logic              drop;
  } drive_row_t;

  localparam int DIR_ROWS = 28;
  localparam int TAIL_ROW = 22;

  drive_row_t dir_rows [DIR_ROWS] = '{
    // empty queue after reset
    '{1'b0, 7'd0,   MODE_QUERY,   16'h0,    '0, '0, '0, 1'b1, ST_OK,      0, 1'b0},
    '{1'b0, 7'd0,   MODE_DEQ,     16'h0,    '0, '0, '0, 1'b1, ST_EMPTY,   0, 1'b0},
    // field extremes
    '{1'b0, 7'd0,   MODE_ENQ,     16'h0,    '0, '0, '0, 1'b1, ST_OK,      1, 1'b0},
    '{1'b0, 7'd0,   MODE_ENQ,     16'hffff, '1, '1, '1, 1'b1, ST_OK,      2, 1'b0},
    // checked enqueue: type 0 and types past the limit are rejected
    '{1'b0, 7'd0,   MODE_ENQ_CHK, 16'h0,    '1, '1, '1, 1'b1, ST_BADTYPE, 2, 1'b0},
    '{1'b0, 7'd0,   MODE_ENQ_CHK, 16'd10001, '1, '1, '1, 1'b1, ST_BADTYPE, 2, 1'b0},
    '{1'b0, 7'd0,   MODE_ENQ_CHK, 16'd10000, 32'h5a5a_5a5a, 32'd64, 32'h1234_5678,
      1'b1, ST_OK, 3, 1'b0},
    '{1'b0, 7'd0,   MODE_ENQ_CHK, 16'd1,    32'ha5a5_a5a5, 32'd1, 32'hdead_beef,
      1'b1, ST_OK, 4, 1'b0},
    '{1'b0, 7'd0,   MODE_DEQ,     16'h0,    '0, '0, '0, 1'b0, ST_OK,     -1, 1'b0},
    '{1'b0, 7'd0,   MODE_SPARE6,  16'h0,    '0, '0, '0, 1'b0, ST_OK,     -1, 1'b0},
    '{1'b0, 7'd0,   MODE_CLEAR,   16'h0,    '0, '0, '0, 1'b1, ST_OK,      0, 1'b0},
    '{1'b0, 7'd0,   MODE_DEQ,     16'h0,    '0, '0, '0, 1'b1, ST_EMPTY,   0, 1'b0},
    // limit of 2: the third enqueue evicts the oldest
    '{1'b1, 7'd2,   MODE_QUERY,   16'h0,    '0, '0, '0, 1'b0, ST_OK,     -1, 1'b0},
    '{1'b0, 7'd0,   MODE_ENQ,     16'h0011, 32'd1, 32'd100, 32'd7, 1'b1, ST_OK, 1, 1'b0},
    '{1'b0, 7'd0,   MODE_ENQ,     16'h0022, 32'd2, 32'd200, 32'd8, 1'b1, ST_OK, 2, 1'b0},
    '{1'b0, 7'd0,   MODE_ENQ,     16'h0033, 32'd3, 32'd300, 32'd9, 1'b1, ST_OK, 2, 1'b1},
    // limit above the depth acts as the depth
    '{1'b1, 7'd127, MODE_QUERY,   16'h0,    '0, '0, '0, 1'b0, ST_OK,     -1, 1'b0},
    '{1'b0, 7'd0,   MODE_ENQ,     16'h0044, 32'd4, 32'd400, 32'd10, 1'b1, ST_OK, 3, 1'b0},
    // limit lowered below occupancy: one eviction, occupancy holds
    '{1'b1, 7'd1,   MODE_QUERY,   16'h0,    '0, '0, '0, 1'b0, ST_OK,     -1, 1'b0},
    '{1'b0, 7'd0,   MODE_ENQ,     16'h0055, 32'd5, 32'd500, 32'd11, 1'b1, ST_OK, 3, 1'b1},
    '{1'b0, 7'd0,   MODE_DEQ,     16'h0,    '0, '0, '0, 1'b0, ST_OK,     -1, 1'b0},
    '{1'b0, 7'd0,   MODE_CLEAR,   16'h0,    '0, '0, '0, 1'b0, ST_OK,     -1, 1'b0},
    // stop, then every code reports stopped, bad type included
    '{1'b0, 7'd0,   MODE_STOP,    16'h0,    '0, '0, '0, 1'b1, ST_OK,     -1, 1'b0},
    '{1'b0, 7'd0,   MODE_ENQ_CHK, 16'h0,    '0, '0, '0, 1'b1, ST_STOPPED, -1, 1'b0},
    '{1'b0, 7'd0,   MODE_DEQ,     16'h0,    '0, '0, '0, 1'b1, ST_STOPPED, -1, 1'b0},
    '{1'b0, 7'd0,   MODE_CLEAR,   16'h0,    '0, '0, '0, 1'b1, ST_STOPPED, -1, 1'b0},
    '{1'b0, 7'd0,   MODE_SPARE7,  16'h0,    '0, '0, '0, 1'b1, ST_STOPPED, -1, 1'b0},
    '{1'b0, 7'd0,   MODE_STOP,    16'h0,    '0, '0, '0, 1'b1, ST_STOPPED, -1, 1'b0}
  };

  task automatic walk_rows(input int first, input int last);
    req_t op;
    for (int i = first; i < last; i++) begin
      if (dir_rows[i].is_cfg) begin
        wait_drained();
        write_limit(dir_rows[i].limit);
      end else begin
        op = {dir_rows[i].mode, dir_rows[i].ptype, dir_rows[i].client,
              dir_rows[i].len, dir_rows[i].crc};
        send_op(op, dir_rows[i].typed, dir_rows[i].st, dir_rows[i].occ,
                dir_rows[i].drop);
      end
    end
  endtask

  // -------------------------------------------------------------------------
  // Random operations
  // -------------------------------------------------------------------------
  function automatic req_t random_op(input int enq_pct, input int deq_pct);
    req_t r;
    int   pick;
    r.packet_type    = 16'($urandom);
    r.client_ident   = $urandom;
    r.payload_crc    = $urandom;
    pick             = $urandom_range(99);
    case ($urandom_range(9))
      0:       r.payload_length = '0;
      1:       r.payload_length = '1;
      2:       r.payload_length = $urandom_range(1500);
      default: r.payload_length = $urandom;
    endcase
    if (r.payload_length == 0 && $urandom_range(1)) r.payload_crc = '0;
    if (pick < enq_pct) begin
      if ($urandom_range(1)) begin
        r.mode = MODE_ENQ_CHK;
        // mostly good types, with the rejection boundaries mixed in
        case ($urandom_range(9))
          0:       r.packet_type = 16'd0;
          1:       r.packet_type = TypeLimit;
          2:       r.packet_type = TypeLimit + 16'd1;
          3:       r.packet_type = 16'($urandom);
          default: r.packet_type = 16'($urandom_range(1, TypeLimit));
        endcase
      end else begin
        r.mode = MODE_ENQ;
      end
    end else if (pick < enq_pct + deq_pct) begin
      r.mode = MODE_DEQ;
    end else if (pick < enq_pct + deq_pct + 3) begin
      r.mode = MODE_CLEAR;
    end else begin
      case ($urandom_range(2))
        0:       r.mode = MODE_QUERY;
        1:       r.mode = MODE_SPARE6;
        default: r.mode = MODE_SPARE7;
      endcase
    end
    return r;
  endfunction

  // Limit per phase; phases rotate between filling, mixed and draining.
  logic [LimitW-1:0] phase_limit [NUM_PHASES] =
    '{7'd0, 7'd64, 7'd1, 7'd2, 7'd127, 7'd65, 7'd3, 7'd8, 7'd63, 7'd0, 7'd5, 7'd16};

  // -------------------------------------------------------------------------
  // Run-length watchdog
  // -------------------------------------------------------------------------
  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("Timeout: run exceeded %0d cycles", CYCLE_LIMIT);
    $display("CHECKS FAILED");
    $finish;
  end

  // -------------------------------------------------------------------------
  // Main sequence
  // -------------------------------------------------------------------------
  initial begin : stimulus
    int enq_pct;
    int deq_pct;

    rst_ni         = 1'b0;
    cfg_we_i       = 1'b0;
    cfg_wdata_i    = '0;
    req_if.valid   = 1'b0;
    req_if.data    = '0;
    calm           = 1'b0;
    stall_rsp_req  = 1'b0;
    mismatch_count = 0;
    results_seen   = 0;
    limit_writes   = 0;
    foreach (op_count[i]) op_count[i] = 0;

    // predicted state matches the block after reset
    q_head    = 0;
    q_count   = 0;
    q_bytes   = '0;
    q_enq     = '0;
    q_deq     = '0;
    q_drop    = '0;
    q_stopped = 1'b0;
    q_limit   = '0;

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);
    write_limit('0);

    walk_rows(0, TAIL_ROW);

    for (int p = 0; p < NUM_PHASES; p++) begin
      // every limit change waits for a quiet queue
      wait_drained();
      write_limit(phase_limit[p]);
      case (p % 3)
        0:       begin enq_pct = 75; deq_pct = 18; end
        1:       begin enq_pct = 55; deq_pct = 38; end
        default: begin enq_pct = 35; deq_pct = 58; end
      endcase
      calm = (p == 6);
      if (p == 4) stall_rsp_req = 1'b1;
      for (int n = 0; n < PHASE_OPS; n++) begin
        send_op(random_op(enq_pct, deq_pct), 1'b0, ST_OK, -1, 1'b0);
      end
      calm = 1'b0;
    end

    wait_drained();
    walk_rows(TAIL_ROW, DIR_ROWS);

    // drain the last results and let the block sit quiet before the summary
    req_if.valid <= 1'b0;
    while (queue_results_due.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);

    $display("Covered %0d enqueue, %0d checked enqueue, %0d dequeue, %0d clear, %0d stop, %0d query",
             op_count[MODE_ENQ], op_count[MODE_ENQ_CHK], op_count[MODE_DEQ],
             op_count[MODE_CLEAR], op_count[MODE_STOP],
             op_count[MODE_QUERY] + op_count[MODE_SPARE6] + op_count[MODE_SPARE7]);
    $display("Checked %0d results across %0d limit settings, %0d oldest-entry evictions",
             results_seen, limit_writes, q_drop);
    if (mismatch_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
